>>> sv/ismx_pkg.sv
// Shared constants and types for the int8 softmax core.
// No dependencies.
package ismx_pkg;

    localparam int MaxLen    = 64;
    localparam int IdxW      = 6;
    localparam int CntW      = 7;
    localparam int ExpW      = 48;
    localparam int SumW      = 54;
    localparam int FactW     = 61;
    localparam int PaddrW    = 4;

    // Register byte addresses.
    localparam logic [PaddrW-1:0] ADDR_LN2   = 4'h0;
    localparam logic [PaddrW-1:0] ADDR_LIN   = 4'h4;
    localparam logic [PaddrW-1:0] ADDR_CONST = 4'h8;

    // Reset values of the registers.
    localparam logic [15:0] LN2_RESET   = 16'hFFA7;
    localparam logic [15:0] LIN_RESET   = 16'd346;
    localparam logic [17:0] CONST_RESET = 18'd45701;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        ST_LOAD  = 10'b0000000001,
        ST_ADDR  = 10'b0000000010,
        ST_RDA   = 10'b0000000100,
        ST_DIV   = 10'b0000001000,
        ST_POLY  = 10'b0000010000,
        ST_SHIFT = 10'b0000100000,
        ST_FDIV  = 10'b0001000000,
        ST_RDB   = 10'b0010000000,
        ST_MUL   = 10'b0100000000,
        ST_EMIT  = 10'b1000000000
    } state_t;

endpackage

>>> sv/ismx_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
// No dependencies.
module ismx_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> sv/int8_softmax_poly_exp_core.sv
// Top level of the int8 integer softmax core with polynomial exponent.
// Depends on ismx_pkg and ismx_ram.
//
// A non-final request stores its logit without raising busy. A final request
// keeps busy high while, per stored element, an address state, a clamp state,
// a 5-step restoring divider for the ln2 quotient, a polynomial state and an
// accumulate state run, then a 61-step bit-serial divider for 2^60/sum (passed
// over when the sum is zero), then per element a read state, a 3-step 16x61
// partial-product multiply and an emit state. Each result is strobed the cycle
// after its emit state and cannot be stalled. Reset is asynchronous, active
// low; it clears the count and resets the running maximum and registers.
module int8_softmax_poly_exp_core
    import ismx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [7:0] sample,
    input  logic              final_req,
    output logic [6:0]        prob,
    output logic              tail,
    output logic              strobe,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [PaddrW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Configuration registers.
    logic [15:0] ln2_reg;
    logic [15:0] lin_reg;
    logic [17:0] const_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ln2_reg   <= LN2_RESET;
            lin_reg   <= LIN_RESET;
            const_reg <= CONST_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                ADDR_LN2:   ln2_reg   <= pwdata[15:0];
                ADDR_LIN:   lin_reg   <= pwdata[15:0];
                ADDR_CONST: const_reg <= pwdata[17:0];
                default:    ;
            endcase
        end
    end

    // Register read mux.
    always_comb
    begin
        unique case (paddr)
            ADDR_LN2:   prdata = {16'd0, ln2_reg};
            ADDR_LIN:   prdata = {16'd0, lin_reg};
            ADDR_CONST: prdata = {14'd0, const_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // Sequencer and datapath registers.
    state_t                state_reg;
    logic [CntW-1:0]       count_reg;
    logic signed [7:0]     max_reg;
    logic [IdxW-1:0]       idx_reg;
    logic [6:0]            step_reg;
    logic [16:0]           rem_reg;      // |x| dividend / remainder (17 bit)
    logic [4:0]            quo_reg;
    logic [ExpW-1:0]       exp_reg;
    logic [SumW-1:0]       sum_reg;
    logic [SumW-1:0]       drem_reg;     // divider partial remainder
    logic [FactW-1:0]      fact_reg;
    logic [80:0]           prod_reg;
    logic                  accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_LOAD);

    // Effective ln2 step magnitude, 1..32768.
    logic [16:0] step_mag;
    assign step_mag = ln2_reg[15] ? (17'd0 - {ln2_reg[15], ln2_reg}) : 17'd1;

    // Stores.
    logic [7:0]      logit_rd;
    logic [ExpW-1:0] exp_rd;
    logic            logit_we;
    logic            exp_we;

    assign logit_we = accept && (count_reg != CntW'(MaxLen));
    assign exp_we   = (state_reg == ST_SHIFT);

    ismx_ram #(.Width(8), .Depth(MaxLen)) u_logit_ram (
        .clk   (clk),
        .we    (logit_we),
        .waddr (count_reg[IdxW-1:0]),
        .wdata (sample),
        .raddr (idx_reg),
        .rdata (logit_rd)
    );

    ismx_ram #(.Width(ExpW), .Depth(MaxLen)) u_exp_ram (
        .clk   (clk),
        .we    (exp_we),
        .waddr (idx_reg),
        .wdata (exp_reg),
        .raddr (idx_reg),
        .rdata (exp_rd)
    );

    // Clamped distance from max: x = logit - max in -255..0, |x| vs 30*step.
    // Every stored logit is at most the maximum, so the difference is 0..255.
    logic [8:0]  diff;
    logic [21:0] lim_mag;
    logic [21:0] dist_mag;
    assign diff     = {max_reg[7], max_reg} - {logit_rd[7], logit_rd};
    assign lim_mag  = 22'(step_mag) * 22'd30;
    assign dist_mag = {13'd0, diff};

    // One restoring divider step for the quotient of |x| by the step.
    logic [21:0] qtrial;
    assign qtrial = 22'(rem_reg) - (22'(step_mag) << (3'd4 - step_reg[2:0]));

    // Polynomial: r = -rem, p = (r+b)*r + c = rem*(rem-b) + c.
    logic signed [18:0] rb;
    logic signed [37:0] poly;
    assign rb   = $signed({2'b00, rem_reg}) - $signed({3'b000, lin_reg});
    assign poly = 38'($signed({1'b0, rem_reg}) * rb) + 38'($signed({20'd0, const_reg}));

    // Shift with saturation.
    logic [4:0]  shamt;
    logic [36:0] pmag;
    logic [84:0] shifted;
    assign shamt   = 5'd30 - quo_reg;
    assign pmag    = poly[37] ? 37'd0 : poly[36:0];
    assign shifted = 85'(pmag) << shamt;

    // Bit-serial divider: 2^60 / sum, dividend bit is 1 only at bit 60.
    logic [SumW:0] dshift;
    logic          dge;
    assign dshift = {drem_reg, (step_reg == 7'd0)};
    assign dge    = ({1'b0, dshift} >= {2'b00, sum_reg});

    // Partial-product multiply: 16 bits of exp per step.
    logic [76:0] pp;
    assign pp = 77'(exp_rd[step_reg[1:0]*16 +: 16]) * 77'(fact_reg);

    logic [27:0] pr;
    assign pr = prod_reg[80:53];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            max_reg   <= -8'sd128;
            idx_reg   <= '0;
            step_reg  <= '0;
            strobe    <= 1'b0;
            tail      <= 1'b0;
            prob      <= '0;
        end
        else
        begin
            strobe <= 1'b0;
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (count_reg != CntW'(MaxLen))
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (sample > max_reg)
                            begin
                                max_reg <= sample;
                            end
                        end
                        if (final_req)
                        begin
                            idx_reg   <= '0;
                            sum_reg   <= '0;
                            state_reg <= ST_ADDR;
                        end
                    end
                end
                ST_ADDR:
                begin
                    // The logit store registers the element at idx this cycle.
                    state_reg <= ST_RDA;
                end
                ST_RDA:
                begin
                    // Read data is ready this cycle; clamp and load divider.
                    rem_reg   <= 17'((dist_mag > lim_mag) ? lim_mag : dist_mag);
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (!qtrial[21])
                    begin
                        rem_reg <= qtrial[16:0];
                    end
                    quo_reg <= {quo_reg[3:0], !qtrial[21]};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 7'd4)
                    begin
                        state_reg <= ST_POLY;
                    end
                end
                ST_POLY:
                begin
                    state_reg <= ST_SHIFT;
                    exp_reg   <= (shifted[84:ExpW] != '0) ? '1 : shifted[ExpW-1:0];
                end
                ST_SHIFT:
                begin
                    sum_reg <= sum_reg + SumW'(exp_reg);
                    if (7'(idx_reg) + 7'd1 == count_reg)
                    begin
                        step_reg  <= '0;
                        drem_reg  <= '0;
                        fact_reg  <= '0;
                        state_reg <= ST_FDIV;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_ADDR;
                    end
                end
                ST_FDIV:
                begin
                    if (sum_reg == '0)
                    begin
                        fact_reg <= '0;
                        idx_reg  <= '0;
                        state_reg <= ST_RDB;
                    end
                    else
                    begin
                        drem_reg <= dge ? SumW'(dshift - {1'b0, sum_reg}) : dshift[SumW-1:0];
                        fact_reg <= {fact_reg[FactW-2:0], dge};
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == 7'(FactW - 1))
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_RDB;
                        end
                    end
                end
                ST_RDB:
                begin
                    prod_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg <= prod_reg + (81'(pp) << (step_reg[1:0] * 16));
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 7'd2)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    strobe <= 1'b1;
                    prob   <= (pr > 28'd127) ? 7'd127 : pr[6:0];
                    tail   <= (7'(idx_reg) + 7'd1 == count_reg);
                    if (7'(idx_reg) + 7'd1 == count_reg)
                    begin
                        count_reg <= '0;
                        max_reg   <= -8'sd128;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_RDB;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> busy)
        else $error("busy low outside load");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(MaxLen))
        else $error("count overflow");
    a_tail_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        tail && strobe |-> (state_reg == ST_LOAD) && (count_reg == '0))
        else $error("tail did not end vector");
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("back to back strobes");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the int8 integer softmax core.
// Depends on ismx_pkg and int8_softmax_poly_exp_core; vectors are loaded one
// logit per request and every probability is checked against a local predictor.
module testbench
    import ismx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 3000;

    // Register indexes.
    typedef enum int {
        REG_LN2   = 0,
        REG_LIN   = 1,
        REG_CONST = 2
    } reg_idx_t;

    typedef struct packed {
        logic [6:0] prob;
        logic       tail;
    } prob_t;

    typedef struct {
        logic signed [7:0] sample;
        logic              final_req;
        logic              check_fixed;
        logic [6:0]        fixed_prob;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic signed [7:0] sample;
    logic              final_req;
    logic [6:0]        prob;
    logic              tail;
    logic              strobe;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PaddrW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int8_softmax_poly_exp_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .sample   (sample),
        .final_req(final_req),
        .prob     (prob),
        .tail     (tail),
        .strobe   (strobe),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor state: a copy of the registers and the vector being loaded.
    logic signed [15:0] ln2_step_q;
    logic [15:0]        lin_q;
    logic [17:0]        const_q;
    logic signed [7:0]  logits[MaxLen];
    int                 logit_cnt;
    logic signed [7:0]  vec_max;

    prob_t prob_queue[$];
    int    fixed_queue[$];
    bit    failed;
    int    idle_cycles;
    int    sender_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Exponent of one element relative to the vector maximum.
    function automatic longint unsigned poly_exp(input logic signed [7:0] logit,
                                                 input logic signed [7:0] mx);
        longint           s;
        longint           x;
        longint           q;
        longint           r;
        longint           p;
        longint unsigned  lim;
        int               sh;
        s = (ln2_step_q >= 0) ? -1 : longint'(ln2_step_q);
        x = longint'(logit) - longint'(mx);
        if (x < 30 * s)
            x = 30 * s;
        q = x / s;
        r = x - s * q;
        p = (r + longint'(lin_q)) * r + longint'(const_q);
        if (p < 0)
            p = 0;
        sh = 30 - int'(q);
        lim = ((64'd1 << 48) - 1) >> sh;
        if (unsigned'(p) > lim)
            return (64'd1 << 48) - 1;
        return unsigned'(p) << sh;
    endfunction

    // Store one logit; on the last one, queue the probabilities of the vector.
    function automatic void predict_request(input logic signed [7:0] smp,
                                            input logic fin, input logic fixed_ok,
                                            input logic [6:0] fixed_val);
        longint unsigned exps[MaxLen];
        longint unsigned total;
        longint unsigned factor;
        longint unsigned pr;
        prob_t           item;
        if (logit_cnt < MaxLen)
        begin
            logits[logit_cnt] = smp;
            logit_cnt++;
            if (smp > vec_max)
                vec_max = smp;
        end
        if (!fin)
            return;
        total = 0;
        factor = 0;
        for (int i = 0; i < logit_cnt; i++)
        begin
            exps[i] = poly_exp(logits[i], vec_max);
            total += exps[i];
        end
        if (total != 0)
            factor = (64'd1 << 60) / total;
        for (int i = 0; i < logit_cnt; i++)
        begin
            pr = (exps[i] * factor) >> 53;
            if (pr > 127)
                pr = 127;
            item.prob = pr[6:0];
            item.tail = (i + 1 == logit_cnt);
            prob_queue.push_back(item);
            fixed_queue.push_back((fixed_ok && i + 1 == logit_cnt) ? int'(fixed_val) : -1);
        end
        logit_cnt = 0;
        vec_max = -8'sd128;
    endfunction

    // Check every probability as it is strobed out.
    always @(posedge clk)
    begin
        prob_t exp_item;
        int    fixed;
        if (rst_n && strobe)
        begin
            if (prob_queue.size() == 0)
            begin
                $error("unexpected result prob=%0d tail=%0d", prob, tail);
                failed = 1'b1;
            end
            else
            begin
                exp_item = prob_queue.pop_front();
                fixed = fixed_queue.pop_front();
                if (fixed >= 0 && fixed != int'(exp_item.prob))
                begin
                    $error("prob table: expected %0d, predictor %0d", fixed, exp_item.prob);
                    failed = 1'b1;
                end
                if (prob !== exp_item.prob)
                begin
                    $error("prob: expected %0d, actual %0d", exp_item.prob, prob);
                    failed = 1'b1;
                end
                if (tail !== exp_item.tail)
                begin
                    $error("tail: expected %0d, actual %0d", exp_item.tail, tail);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request, no strobe and no register access.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchdogLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Register write through the setup and access phases, then back to idle.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PaddrW'(4 * int'(idx));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LN2:   ln2_step_q = value[15:0];
            REG_LIN:   lin_q = value[15:0];
            default:   const_q = value[17:0];
        endcase
        @(posedge clk);
    endtask

    // Stop sending, then wait for all probabilities to be strobed out.
    task automatic drain();
        start <= 1'b0;
        while (prob_queue.size() != 0)
            @(posedge clk);
        repeat (5)
            @(posedge clk);
    endtask

    // Issue one request; optional random idle beforehand. The request line
    // stays high after acceptance so that requests can follow back to back.
    task automatic send(input logic signed [7:0] smp, input logic fin,
                        input logic fixed_ok, input logic [6:0] fixed_val);
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        sample <= smp;
        final_req <= fin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(smp, fin, fixed_ok, fixed_val);
    endtask

    // A well-formed vector of the given length and random spread.
    task automatic send_vector(input int len);
        int lo;
        int hi;
        lo = $urandom_range(127, 0) - 128;
        hi = $urandom_range(127, lo + 128) - 128 + ($urandom_range(1, 0) ? 127 : 0);
        if (hi > 127)
            hi = 127;
        for (int i = 0; i < len; i++)
            send(8'($urandom_range(hi - lo, 0) + lo), i == len - 1, 1'b0, 7'd0);
    endtask

    stim_row_t directed[] = '{
        // Single element: full probability saturates to 127.
        '{8'sd5,     1'b1, 1'b1, 7'd127},
        // Extremes of the logit range.
        '{-8'sd128,  1'b0, 1'b0, 7'd0},
        '{8'sd127,   1'b1, 1'b0, 7'd0},
        '{8'sd127,   1'b0, 1'b0, 7'd0},
        '{-8'sd128,  1'b1, 1'b0, 7'd0},
        // Equal logits split evenly, rounded down.
        '{8'sd0,     1'b0, 1'b0, 7'd0},
        '{8'sd0,     1'b1, 1'b1, 7'd63},
        '{-8'sd1,    1'b0, 1'b0, 7'd0},
        '{8'sd85,    1'b0, 1'b0, 7'd0},
        '{-8'sd86,   1'b1, 1'b0, 7'd0}
    };

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        final_req = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        failed = 1'b0;
        idle_cycles = 0;
        sender_idle_pct = 0;
        ln2_step_q = LN2_RESET;
        lin_q = LIN_RESET;
        const_q = CONST_RESET;
        logit_cnt = 0;
        vec_max = -8'sd128;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings.
        foreach (directed[i])
            send(directed[i].sample, directed[i].final_req,
                 directed[i].check_fixed, directed[i].fixed_prob);
        drain();

        // Store full: 66 items, the last two dropped, the final one still runs.
        for (int i = 0; i < 66; i++)
            send(8'($urandom_range(255, 0)), i == 65, 1'b0, 7'd0);
        drain();

        // Register extremes: zero polynomial gives a zero sum, large values saturate.
        write_reg(REG_LN2, 32'h0000_7FFF);
        write_reg(REG_LIN, 32'd0);
        write_reg(REG_CONST, 32'd0);
        send(8'sd3, 1'b0, 1'b0, 7'd0);
        send(8'sd3, 1'b1, 1'b1, 7'd0);
        drain();
        write_reg(REG_LN2, 32'h0000_8000);
        write_reg(REG_LIN, 32'h0000_FFFF);
        write_reg(REG_CONST, 32'h0003_FFFF);
        send(-8'sd128, 1'b0, 1'b0, 7'd0);
        send(8'sd127, 1'b1, 1'b0, 7'd0);
        drain();
        write_reg(REG_LN2, 32'h0000_FFFF);
        write_reg(REG_LIN, 32'd2);
        write_reg(REG_CONST, 32'd1);
        send(8'sd10, 1'b0, 1'b0, 7'd0);
        send(8'sd0, 1'b1, 1'b0, 7'd0);
        drain();

        // Random phases with varying idle rates and register settings.
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase == 1) ? 54 : (phase == 3) ? 10 : 0;
            drain();
            if (phase == 3)
            begin
                write_reg(REG_LN2, 32'(16'(-89)));
                write_reg(REG_LIN, 32'd346);
                write_reg(REG_CONST, 32'd45701);
            end
            else
            begin
                write_reg(REG_LN2, 32'(-$urandom_range(200, 1)));
                write_reg(REG_LIN, $urandom_range(65535, 0));
                write_reg(REG_CONST, $urandom_range(262143, 0));
            end
            for (int v = 0; v < 2; v++)
                send_vector(($urandom_range(3, 0) == 0) ? $urandom_range(12, 2)
                                                        : $urandom_range(6, 1));
            // Each phase ends with a two-element random vector.
            send_vector(2);
        end

        drain();
        repeat (DrainCycles / 100)
            @(posedge clk);
        if (!failed && prob_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
